// File: hdl/mrts_pkg.sv
// shared constants, codes and types of the multi-rate tick scheduler
`default_nettype none
package mrts_pkg;

  localparam int MAX_TASKS = 8;
  localparam int SLOT_W    = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int PER_W     = 21;
  localparam int RLD_W     = 17;
  localparam int PRIO_W    = 8;
  localparam int CMD_W     = 2;
  localparam int KIND_W    = 3;

  localparam logic [PER_W-1:0] CLOCK_HZ   = PER_W'(1193182);
  localparam logic [RLD_W-1:0] RELOAD_MAX = RLD_W'(17'h10000);

  // request commands
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_FIRE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ACK     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CHAIN   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ADDED   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FULL    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_REMOVED = 3'd5;
  localparam logic [KIND_W-1:0] KIND_NO_TASK = 3'd6;
  localparam logic [KIND_W-1:0] KIND_CLEARED = 3'd7;

  // classified request as queued between front and back
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [PER_W-1:0]  freq;
    logic [PRIO_W-1:0] prio;
    logic [SLOT_W-1:0] slot;
  } req_t;

endpackage
`default_nettype wire

// File: hdl/mrts_in_if.sv
// request channel: valid/ready handshake with request fields
`default_nettype none
interface mrts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [20:0] tick_base;
  logic [7:0]  task_priority;
  logic [2:0]  slot;

  modport source (output valid, cmd, tick_base, task_priority, slot, input ready);
  modport sink   (input valid, cmd, tick_base, task_priority, slot, output ready);
endinterface
`default_nettype wire

// File: hdl/mrts_out_if.sv
// result channel: valid/ready handshake with result fields
`default_nettype none
interface mrts_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [2:0]  task_slot;
  logic [20:0] task_period;
  logic [16:0] reload;
  logic        last;

  modport source (output valid, kind, task_slot, task_period, reload, last, input ready);
  modport sink   (input valid, kind, task_slot, task_period, reload, last, output ready);
endinterface
`default_nettype wire

// File: hdl/mrts_front.sv
// front stage: accepts requests, clamps the frequency and holds one request
`default_nettype none
module mrts_front import mrts_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  mrts_in_if.sink   in_req,
  output req_t      push_data,
  output logic      push_valid,
  input  wire logic push_ready
);

  logic hold_valid;
  req_t hold;
  req_t classified;

  always_comb begin
    classified.cmd  = in_req.cmd;
    classified.prio = in_req.task_priority;
    classified.slot = in_req.slot;
    // zero counts as one hertz, anything above the clock saturates
    if (in_req.tick_base == '0) begin
      classified.freq = PER_W'(1);
    end else if (in_req.tick_base > CLOCK_HZ) begin
      classified.freq = CLOCK_HZ;
    end else begin
      classified.freq = in_req.tick_base;
    end
  end

  assign in_req.ready = !hold_valid || push_ready;
  assign push_valid   = hold_valid;
  assign push_data    = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_req.ready) begin
      hold_valid <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      hold <= classified;
    end
  end

endmodule
`default_nettype wire

// File: hdl/mrts_fifo.sv
// two-entry request queue between front and back
`default_nettype none
module mrts_fifo import mrts_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire req_t push_data,
  input  wire logic push_valid,
  output logic      push_ready,
  output req_t      pop_data,
  output logic      pop_valid,
  input  wire logic pop_ready
);

  req_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: hdl/mrts_div.sv
// restoring divider: clock rate divided by frequency, one quotient bit a cycle
`default_nettype none
module mrts_div import mrts_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [PER_W-1:0] divisor,
  output logic                  busy,
  output logic [PER_W-1:0]      quotient
);

  localparam int STEP_W = $clog2(PER_W + 1);

  logic [PER_W-1:0]  dvs;
  logic [PER_W-1:0]  dvd;
  logic [PER_W-1:0]  rem;
  logic [STEP_W-1:0] steps;
  logic [PER_W:0]    trial;
  logic              take;

  assign trial = {rem, dvd[PER_W-1]};
  assign take  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= STEP_W'(PER_W);
    end else if (busy) begin
      steps <= steps - STEP_W'(1);
      if (steps == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs      <= divisor;
      dvd      <= CLOCK_HZ;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[PER_W-2:0], 1'b0};
      rem      <= take ? PER_W'(trial - {1'b0, dvs}) : trial[PER_W-1:0];
      quotient <= {quotient[PER_W-2:0], take};
    end
  end

endmodule
`default_nettype wire

// File: hdl/mrts_back.sv
// back engine: task tables, ordered list, tick walk and result register
`default_nettype none
module mrts_back import mrts_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire req_t  pop_data,
  input  wire logic  pop_valid,
  output logic       pop_ready,
  mrts_out_if.source out_res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TICK = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_REM  = 3'd3;

  logic [2:0] state;
  req_t       cur;

  // task tables
  logic [MAX_TASKS-1:0] used;
  logic [PER_W-1:0]     per_store  [MAX_TASKS];
  logic [PER_W-1:0]     acc        [MAX_TASKS];
  logic [PRIO_W-1:0]    prio_store [MAX_TASKS];
  logic [SLOT_W-1:0]    order      [MAX_TASKS];
  logic [SLOT_W-1:0]    order_next [MAX_TASKS];
  logic [CNT_W-1:0]     count;
  logic [RLD_W-1:0]     reload;
  logic [15:0]          legacy;

  // walk state
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  pos;
  logic              found;
  logic [RLD_W-1:0]  best;
  logic [SLOT_W-1:0] new_slot;

  logic              out_free;
  logic              walk_end;
  logic [SLOT_W-1:0] cur_task;
  logic [PER_W-1:0]  acc_sum;
  logic              fires;
  logic [RLD_W-1:0]  legacy_sum;
  logic [SLOT_W-1:0] free_slot;
  logic              div_start;
  logic              div_busy;
  logic [PER_W-1:0]  div_q;
  logic [RLD_W-1:0]  add_reload;
  logic              commit_add;
  logic              commit_rem;
  logic              res_load;

  assign out_free   = !out_res.valid || out_res.ready;
  assign walk_end   = (idx == count);
  assign cur_task   = order[idx[SLOT_W-1:0]];
  assign acc_sum    = acc[cur_task] + PER_W'(reload);
  assign fires      = (acc_sum >= per_store[cur_task]);
  assign legacy_sum = RLD_W'(legacy) + reload;
  assign pop_ready  = (state == S_IDLE) && out_free;
  assign div_start  = (state == S_IDLE) && pop_valid && out_free
                      && (pop_data.cmd == CMD_ADD) && !count[CNT_W-1];
  assign add_reload = (div_q < PER_W'(reload)) ? RLD_W'(div_q) : reload;
  assign commit_add = (state == S_ADD) && walk_end && !div_busy && out_free;
  assign commit_rem = (state == S_REM) && walk_end && out_free;

  // a new result is loaded into the output register this cycle
  always_comb begin
    res_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (pop_valid && out_free) begin
          unique case (pop_data.cmd)
            CMD_ADD:    res_load = count[CNT_W-1];
            CMD_REMOVE: res_load = !used[pop_data.slot];
            CMD_CLEAR:  res_load = 1'b1;
            default:    res_load = 1'b0;
          endcase
        end
      end
      S_TICK:  res_load = out_free && (walk_end || fires);
      S_ADD:   res_load = commit_add;
      S_REM:   res_load = commit_rem;
      default: res_load = 1'b0;
    endcase
  end

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int k = MAX_TASKS - 1; k >= 0; k--) begin
      if (!used[k]) begin
        free_slot = SLOT_W'(k);
      end
    end
  end

  // list insert and unlink, each entry taking a neighbor or staying
  always_comb begin
    for (int j = 0; j < MAX_TASKS; j++) begin
      order_next[j] = order[j];
      if (commit_add) begin
        if (CNT_W'(j) == pos) begin
          order_next[j] = new_slot;
        end else if (CNT_W'(j) > pos && CNT_W'(j) <= count && j > 0) begin
          order_next[j] = order[(j + MAX_TASKS - 1) % MAX_TASKS];
        end
      end else if (commit_rem) begin
        if (CNT_W'(j) >= pos && CNT_W'(j + 1) < count && j + 1 < MAX_TASKS) begin
          order_next[j] = order[(j + 1) % MAX_TASKS];
        end
      end
    end
  end

  mrts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (pop_data.freq),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_TASKS; j++) begin
      order[j] <= order_next[j];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      used          <= '0;
      count         <= '0;
      reload        <= RELOAD_MAX;
      legacy        <= '0;
      out_res.valid <= 1'b0;
    end else begin
      out_res.valid <= res_load || (out_res.valid && !out_res.ready);
      unique case (state)
        S_IDLE: begin
          if (pop_valid && out_free) begin
            unique case (pop_data.cmd)
              CMD_TICK: begin
                state <= S_TICK;
              end
              CMD_ADD: begin
                if (!count[CNT_W-1]) begin
                  state <= S_ADD;
                end
              end
              CMD_REMOVE: begin
                if (used[pop_data.slot]) begin
                  state <= S_REM;
                end
              end
              CMD_CLEAR: begin
                used   <= '0;
                count  <= '0;
                reload <= RELOAD_MAX;
                legacy <= '0;
              end
              default: ;
            endcase
          end
        end
        S_TICK: begin
          if (out_free && walk_end) begin
            legacy <= legacy_sum[15:0];
            state  <= S_IDLE;
          end
        end
        S_ADD: begin
          if (commit_add) begin
            used[new_slot] <= 1'b1;
            count          <= count + CNT_W'(1);
            reload         <= add_reload;
            state          <= S_IDLE;
          end
        end
        S_REM: begin
          if (commit_rem) begin
            used[cur.slot] <= 1'b0;
            count          <= count - CNT_W'(1);
            reload         <= best;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload, tables and walk registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (pop_valid && out_free) begin
          cur      <= pop_data;
          idx      <= '0;
          pos      <= count;
          found    <= 1'b0;
          best     <= RELOAD_MAX;
          new_slot <= free_slot;
          out_res.task_slot   <= '0;
          out_res.task_period <= '0;
          out_res.reload      <= (pop_data.cmd == CMD_CLEAR) ? RELOAD_MAX : reload;
          out_res.last        <= 1'b1;
          unique case (pop_data.cmd)
            CMD_ADD:    out_res.kind <= KIND_FULL;
            CMD_REMOVE: out_res.kind <= KIND_NO_TASK;
            CMD_CLEAR:  out_res.kind <= KIND_CLEARED;
            default:    out_res.kind <= KIND_ACK;
          endcase
        end
      end
      S_TICK: begin
        if (out_free) begin
          out_res.task_period <= '0;
          out_res.reload      <= reload;
          if (!walk_end) begin
            idx <= idx + CNT_W'(1);
            if (fires) begin
              acc[cur_task]     <= acc_sum - per_store[cur_task];
              out_res.kind      <= KIND_FIRE;
              out_res.task_slot <= cur_task;
              out_res.last      <= 1'b0;
            end else begin
              acc[cur_task] <= acc_sum;
            end
          end else begin
            out_res.kind      <= legacy_sum[16] ? KIND_CHAIN : KIND_ACK;
            out_res.task_slot <= '0;
            out_res.last      <= 1'b1;
          end
        end
      end
      S_ADD: begin
        if (!walk_end) begin
          idx <= idx + CNT_W'(1);
          // new task goes ahead of the first one with equal or larger key
          if (!found && cur.prio <= prio_store[cur_task]) begin
            found <= 1'b1;
            pos   <= idx;
          end
        end else if (commit_add) begin
          per_store[new_slot]  <= div_q;
          acc[new_slot]        <= '0;
          prio_store[new_slot] <= cur.prio;
          out_res.kind         <= KIND_ADDED;
          out_res.task_slot    <= new_slot;
          out_res.task_period  <= div_q;
          out_res.reload       <= add_reload;
          out_res.last         <= 1'b1;
        end
      end
      S_REM: begin
        if (!walk_end) begin
          idx <= idx + CNT_W'(1);
          if (cur_task == cur.slot) begin
            pos <= idx;
          end else if (per_store[cur_task] < PER_W'(best)) begin
            best <= RLD_W'(per_store[cur_task]);
          end
        end else if (commit_rem) begin
          out_res.kind        <= KIND_REMOVED;
          out_res.task_slot   <= cur.slot;
          out_res.task_period <= '0;
          out_res.reload      <= best;
          out_res.last        <= 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/multi_rate_tick_task_scheduler_core.sv
// top level of the multi-rate tick task scheduler
`default_nettype none
// Keeps up to eight periodic tasks in priority order and steps them on each
// timer tick request. The front stage takes a request, clamps the frequency
// and hands it through a two-entry queue to the back engine, so requests keep
// flowing in while the engine works or waits on a stalled result. In the
// engine, a tick walks the ordered list task by task, pausing whenever the
// result side stalls; an add runs the 21-step restoring divider that forms
// the period and finds the list position alongside it; a remove walks the
// list to find the entry and the new smallest period; clear, full and
// unknown-slot requests are answered straight from idle without a walk. Each
// request yields one or more results, the final one marked by last.
module multi_rate_tick_task_scheduler_core import mrts_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  mrts_in_if.sink    in_req,
  mrts_out_if.source out_res
);

  // queue between front and back
  req_t push_data;
  logic push_valid;
  logic push_ready;
  req_t pop_data;
  logic pop_valid;
  logic pop_ready;

  // front: accept and classify
  mrts_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_req     (in_req),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  // short queue so each side can stall on its own
  mrts_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  // back: tables, list walk, divider and result register
  mrts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_data  (pop_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .out_res   (out_res)
  );

endmodule
`default_nettype wire
